@@ src/ip_address_text_formatter_unit_defines.svh @@
// Assertion shorthands used by the assertion checker module.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef IP_ADDRESS_TEXT_FORMATTER_UNIT_DEFINES_SVH
`define IP_ADDRESS_TEXT_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/iptf_pkg.sv @@
package iptf_pkg;

    localparam int NUM_GROUPS = 8;

    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_COLON   = 7'h3a;
    localparam logic [6:0] CH_DOT     = 7'h2e;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_F = 7'h66;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_F = 7'h46;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } iptf_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic step;
    } iptf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic char_last;
    } iptf_stat_t;

    // Index of the most significant nonzero hex digit; a zero group prints one digit.
    function automatic logic [1:0] hex_top(input logic [15:0] w);
        logic [1:0] top;
        if (w[15:12] != 4'd0) top = 2'd3;
        else if (w[11:8] != 4'd0) top = 2'd2;
        else if (w[7:4] != 4'd0) top = 2'd1;
        else top = 2'd0;
        return top;
    endfunction

    function automatic logic [1:0] dec_top(input logic [7:0] v);
        logic [1:0] top;
        if (v >= 8'd100) top = 2'd2;
        else if (v >= 8'd10) top = 2'd1;
        else top = 2'd0;
        return top;
    endfunction

    // Decimal digit of an octet: position 2 is hundreds, 1 tens, 0 ones.
    // Tens come from a multiply by 205/2048, exact for values below 100.
    function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  o;
        logic [3:0]  d;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - 8'(h) * 8'd100;
        prod = 15'(r[6:0]) * 15'd205;
        t = prod[14:11];
        o = r[6:0] - 7'(t) * 7'd10;
        unique case (pos)
            2'd2:    d = 4'(h);
            2'd1:    d = t;
            default: d = o[3:0];
        endcase
        return d;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10) c = CH_ZERO + 7'(d);
        else c = (upper ? CH_UPPER_A : CH_LOWER_A) + 7'(d - 4'd10);
        return c;
    endfunction

endpackage

@@ src/iptf_if.sv @@
interface iptf_addr_if;
    logic        valid;
    logic        ready;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;

    modport source (output valid, output is_v6, output addr_hi, output addr_lo, input ready);
    modport sink (input valid, input is_v6, input addr_hi, input addr_lo, output ready);
endinterface

interface iptf_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

@@ src/iptf_datapath.sv @@
module iptf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 is_v6,
    input  logic [63:0]          addr_hi,
    input  logic [63:0]          addr_lo,
    input  iptf_pkg::iptf_cmd_t  cmd,
    output iptf_pkg::iptf_stat_t stat,
    input  logic                 txt_ready,
    output logic                 txt_valid,
    output logic [6:0]           char_code,
    output logic                 last_char
);
    import iptf_pkg::*;

    logic        upper_reg;
    logic [63:0] addr_hi_reg;
    logic [63:0] addr_lo_reg;
    logic        v6_reg;
    logic [3:0]  run_start_reg;
    logic [3:0]  run_len_reg;
    logic [3:0]  grp_reg;
    logic [1:0]  dig_reg;
    logic        sep_reg;
    logic        dbl_reg;
    logic        txt_valid_reg;
    logic [6:0]  char_reg;
    logic        last_reg;

    logic [3:0]  grp_next;
    logic [1:0]  dig_next;
    logic        sep_next;
    logic        dbl_next;

    logic [127:0] addr_all;
    logic [7:0]   zero_grp;
    logic [3:0]   scan_start;
    logic [3:0]   scan_len;
    logic [1:0]   top_first;
    logic         run_here;
    logic [3:0]   run_end;
    logic [3:0]   gsel;
    logic [15:0]  cur_word;
    logic [7:0]   cur_octet;
    logic [15:0]  nxt_word;
    logic [7:0]   nxt_octet;
    logic [1:0]   top_next;
    logic [6:0]   ch;
    logic         is_last;

    assign addr_all = {addr_hi_reg, addr_lo_reg};

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            zero_grp[g] = (addr_all[127 - 16 * g -: 16] == 16'd0);
        end
    end

    // Longest run of zero groups; a strictly longer run replaces the best so far.
    always_comb
    begin : scan_blk
        logic [3:0] cur_s;
        logic [3:0] cur_l;
        logic [3:0] best_s;
        logic [3:0] best_l;
        cur_s  = 4'd0;
        cur_l  = 4'd0;
        best_s = 4'hf;
        best_l = 4'd0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (zero_grp[g])
            begin
                if (cur_l == 4'd0)
                begin
                    cur_s = 4'(g);
                end
                cur_l = cur_l + 4'd1;
                if (cur_l > best_l)
                begin
                    best_l = cur_l;
                    best_s = cur_s;
                end
            end
            else
            begin
                cur_l = 4'd0;
            end
        end
        scan_start = v6_reg ? best_s : 4'hf;
        scan_len   = v6_reg ? best_l : 4'd0;
    end

    assign top_first = v6_reg ? hex_top(addr_hi_reg[63:48]) : dec_top(addr_lo_reg[31:24]);

    assign run_here  = v6_reg && (run_len_reg != 4'd0) && (grp_reg == run_start_reg);
    assign run_end   = grp_reg + run_len_reg;
    assign gsel      = (run_here && dbl_reg) ? run_end : grp_reg + 4'd1;

    assign cur_word  = addr_all[{3'd7 - grp_reg[2:0], 4'b0000} +: 16];
    assign cur_octet = addr_lo_reg[{~grp_reg[1:0], 3'b000} +: 8];
    assign nxt_word  = addr_all[{3'd7 - gsel[2:0], 4'b0000} +: 16];
    assign nxt_octet = addr_lo_reg[{~gsel[1:0], 3'b000} +: 8];
    assign top_next  = v6_reg ? hex_top(nxt_word) : dec_top(nxt_octet);

    always_comb
    begin
        ch       = CH_COLON;
        is_last  = 1'b0;
        grp_next = grp_reg;
        dig_next = dig_reg;
        sep_next = sep_reg;
        dbl_next = dbl_reg;
        if (v6_reg)
        begin
            if (run_here)
            begin
                ch = CH_COLON;
                if (!dbl_reg)
                begin
                    dbl_next = 1'b1;
                end
                else
                begin
                    dbl_next = 1'b0;
                    sep_next = 1'b0;
                    grp_next = run_end;
                    dig_next = top_next;
                    is_last  = (run_end == 4'd8);
                end
            end
            else if (sep_reg)
            begin
                ch       = CH_COLON;
                sep_next = 1'b0;
            end
            else
            begin
                ch = hex_char(cur_word[{dig_reg, 2'b00} +: 4], upper_reg);
                if (dig_reg == 2'd0)
                begin
                    is_last  = (grp_reg == 4'd7);
                    grp_next = grp_reg + 4'd1;
                    sep_next = 1'b1;
                    dig_next = top_next;
                end
                else
                begin
                    dig_next = dig_reg - 2'd1;
                end
            end
        end
        else
        begin
            if (sep_reg)
            begin
                ch       = CH_DOT;
                sep_next = 1'b0;
            end
            else
            begin
                ch = CH_ZERO + 7'(dec_digit(cur_octet, dig_reg));
                if (dig_reg == 2'd0)
                begin
                    is_last  = (grp_reg == 4'd3);
                    grp_next = grp_reg + 4'd1;
                    sep_next = 1'b1;
                    dig_next = top_next;
                end
                else
                begin
                    dig_next = dig_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg     <= 1'b0;
            run_start_reg <= 4'hf;
            run_len_reg   <= 4'd0;
            grp_reg       <= 4'd0;
            dig_reg       <= 2'd0;
            sep_reg       <= 1'b0;
            dbl_reg       <= 1'b0;
            txt_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                upper_reg <= cfg_wr_data;
            end
            if (cmd.scan)
            begin
                run_start_reg <= scan_start;
                run_len_reg   <= scan_len;
                grp_reg       <= 4'd0;
                dig_reg       <= top_first;
                sep_reg       <= 1'b0;
                dbl_reg       <= 1'b0;
            end
            else if (cmd.step)
            begin
                grp_reg <= grp_next;
                dig_reg <= dig_next;
                sep_reg <= sep_next;
                dbl_reg <= dbl_next;
            end
            if (cmd.step)
            begin
                txt_valid_reg <= 1'b1;
            end
            else if (txt_ready)
            begin
                txt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_hi_reg <= addr_hi;
            addr_lo_reg <= addr_lo;
            v6_reg      <= is_v6;
        end
        if (cmd.step)
        begin
            char_reg <= ch;
            last_reg <= is_last;
        end
    end

    assign stat.out_free  = !txt_valid_reg || txt_ready;
    assign stat.char_last = is_last;
    assign txt_valid      = txt_valid_reg;
    assign char_code      = char_reg;
    assign last_char      = last_reg;

endmodule

@@ src/iptf_ctrl.sv @@
module iptf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 addr_valid,
    output logic                 addr_ready,
    input  iptf_pkg::iptf_stat_t stat,
    output iptf_pkg::iptf_cmd_t  cmd
);
    import iptf_pkg::*;

    iptf_state_t state_reg;
    iptf_state_t state_next;

    always_comb
    begin
        cmd        = '0;
        addr_ready = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                addr_ready = 1'b1;
                if (addr_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    // The next address may come in with the final character.
                    if (stat.char_last)
                    begin
                        addr_ready = 1'b1;
                        if (addr_valid)
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/ip_address_text_formatter_unit.sv @@
// IP address text formatter.
// The addr_ch channel takes one address per transfer: is_v6 selects IPv4
// (dotted decimal from addr_lo[31:0]) or IPv6 (eight hex groups, addr_hi first).
// The char_ch channel returns the text one ASCII character per transfer,
// with last_char set on the final character of each address.
// For IPv6 the longest run of zero groups, left-most on a tie, becomes "::".
// cfg_wr_en/cfg_wr_data write the upper case hex select; write it only while idle.
// Operation: after an address transfer, the scan state finds the zero run, then
// one character per cycle is produced into an output register while that
// register is free. The first character is registered at the first step after
// the scan. An address has 2 to 39 characters; the next address is taken in
// the cycle that produces the final character, so back-to-back addresses are
// separated only by the scan of the next one.
// When the receiver holds char_ch.ready low, the held character stays put and
// character production pauses; addr_ch.ready stays low until the last
// character of the current address has been produced.
// Reset clears the controller, the output valid flag and the hex case select.
module ip_address_text_formatter_unit (
    input logic         clk,
    input logic         rst_n,
    input logic         cfg_wr_en,
    input logic         cfg_wr_data,
    iptf_addr_if.sink   addr_ch,
    iptf_char_if.source char_ch
);
    import iptf_pkg::*;

    iptf_cmd_t  cmd;
    iptf_stat_t stat;

    // Sequencer: idle, zero-run scan, then character emission.
    iptf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .addr_valid (addr_ch.valid),
        .addr_ready (addr_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Address store, zero-run finder, character generator and output register.
    iptf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .is_v6       (addr_ch.is_v6),
        .addr_hi     (addr_ch.addr_hi),
        .addr_lo     (addr_ch.addr_lo),
        .cmd         (cmd),
        .stat        (stat),
        .txt_ready   (char_ch.ready),
        .txt_valid   (char_ch.valid),
        .char_code   (char_ch.char_code),
        .last_char   (char_ch.last_char)
    );

endmodule

@@ src/iptf_checker.sv @@
`include "ip_address_text_formatter_unit_defines.svh"

module iptf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       addr_valid,
    input logic       addr_ready,
    input logic       txt_valid,
    input logic       txt_ready,
    input logic [6:0] char_code,
    input logic       last_char
);
    import iptf_pkg::*;

    logic       addr_take;
    logic       char_ok;
    logic       stall;
    logic [7:0] out_word;

    assign addr_take = addr_valid && addr_ready;
    assign char_ok   = (char_code >= CH_ZERO && char_code <= CH_COLON) ||
                       (char_code == CH_DOT) ||
                       (char_code >= CH_LOWER_A && char_code <= CH_LOWER_F) ||
                       (char_code >= CH_UPPER_A && char_code <= CH_UPPER_F);
    assign stall     = txt_valid && !txt_ready;
    assign out_word  = {char_code, last_char};

    // A new address always goes through its scan state before another is taken.
    `IPTF_ASSERT_NXT(a_scan_after_take, addr_take, !addr_ready, "address taken during scan")

    // Only digits, hex letters, colons and dots ever appear.
    `IPTF_ASSERT_IMP(a_char_set, txt_valid, char_ok, "character outside the address alphabet")

    // Text never ends on a separator dot.
    `IPTF_ASSERT_IMP(a_last_not_dot, txt_valid && last_char, char_code != CH_DOT, "final dot")

    // A stalled character holds.
    `IPTF_ASSERT_NXT(a_hold, stall, txt_valid && $stable(out_word), "stalled character changed")

endmodule

bind ip_address_text_formatter_unit iptf_checker u_iptf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .addr_valid (addr_ch.valid),
    .addr_ready (addr_ch.ready),
    .txt_valid  (char_ch.valid),
    .txt_ready  (char_ch.ready),
    .char_code  (char_ch.char_code),
    .last_char  (char_ch.last_char)
);

@@ tb/iptf_text_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the formatter, builds the expected text of every
// accepted address and compares each character transfer against it in order.
module iptf_text_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        addr_valid,
    input  logic        addr_ready,
    input  logic        is_v6,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [6:0]  char_code,
    input  logic        last_char,
    output int          pending_chars,
    output int          mismatches
);
    import iptf_pkg::*;

    typedef struct packed {
        logic [6:0] code;
        logic       is_last;
    } text_char_t;

    logic       upper_hex;
    text_char_t expected_text[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void push_char(input logic [6:0] c);
        text_char_t ch;
        ch.code    = c;
        ch.is_last = 1'b0;
        expected_text.push_back(ch);
    endfunction

    // Appends the full text of one address, flagging its final character.
    function automatic void format_address(input logic v6, input logic [63:0] hi,
                                           input logic [63:0] lo);
        logic [15:0] grp [NUM_GROUPS];
        logic [7:0]  octet;
        logic [3:0]  d;
        int          run_start;
        int          run_len;
        int          cur_start;
        int          cur_len;
        int          g;
        int          top;
        bit          need_colon;
        if (!v6)
        begin
            for (int i = 0; i < 4; i++)
            begin
                octet = lo[31 - 8 * i -: 8];
                if (i > 0)
                    push_char(CH_DOT);
                if (octet >= 8'd100)
                    push_char(CH_ZERO + 7'(octet / 8'd100));
                if (octet >= 8'd10)
                    push_char(CH_ZERO + 7'((octet / 8'd10) % 8'd10));
                push_char(CH_ZERO + 7'(octet % 8'd10));
            end
        end
        else
        begin
            for (int i = 0; i < NUM_GROUPS; i++)
                grp[i] = (i < 4) ? hi[63 - 16 * i -: 16] : lo[63 - 16 * (i - 4) -: 16];
            // Longest zero run; a strictly longer run is needed to displace
            // an earlier one, so the left-most run wins a tie.
            run_start = NUM_GROUPS;
            run_len   = 0;
            cur_start = 0;
            cur_len   = 0;
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                if (grp[i] == 16'd0)
                begin
                    if (cur_len == 0)
                        cur_start = i;
                    cur_len++;
                    if (cur_len > run_len)
                    begin
                        run_len   = cur_len;
                        run_start = cur_start;
                    end
                end
                else
                begin
                    cur_len = 0;
                end
            end
            need_colon = 1'b0;
            g = 0;
            while (g < NUM_GROUPS)
            begin
                if (run_len > 0 && g == run_start)
                begin
                    push_char(CH_COLON);
                    push_char(CH_COLON);
                    need_colon = 1'b0;
                    g += run_len;
                end
                else
                begin
                    if (need_colon)
                        push_char(CH_COLON);
                    top = 3;
                    while (top > 0 && grp[g][4 * top +: 4] == 4'd0)
                        top--;
                    for (int nib = top; nib >= 0; nib--)
                    begin
                        d = grp[g][4 * nib +: 4];
                        if (d < 4'd10)
                            push_char(CH_ZERO + 7'(d));
                        else
                            push_char((upper_hex ? CH_UPPER_A : CH_LOWER_A) + 7'(d - 4'd10));
                    end
                    need_colon = 1'b1;
                    g++;
                end
            end
        end
        expected_text[expected_text.size() - 1].is_last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            upper_hex = 1'b0;
            expected_text.delete();
            pending_chars <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                upper_hex = cfg_wr_data;
            // Characters leave only after their address has passed the load and scan
            // steps, so checking before predicting at the same edge keeps the order.
            if (char_valid && char_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("character 0x%02h (last %b) with no text pending",
                                              char_code, last_char));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.code)
                        report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                                  char_code, want.code));
                    if (last_char !== want.is_last)
                        report_mismatch($sformatf("last_char %b, expected %b on char 0x%02h",
                                                  last_char, want.is_last, want.code));
                end
            end
            if (addr_valid && addr_ready)
                format_address(is_v6, addr_hi, addr_lo);
            pending_chars <= expected_text.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Top of the formatter testbench. It generates clock and reset, drives the
// address channel and the hex case register, plays the receiver on the
// character channel, and gives the verdict. Text checking lives in the
// checker instance, which reports its mismatch count back to this module.
module tb_top;

    import iptf_pkg::*;

    // The slowest legal run is far below this: about 170 addresses of at most
    // 39 characters, each character stalled by a random hold-off, plus one long
    // receiver hold-off.
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PER_PASS = 50;
    // Character count at which the receiver stops taking characters for a
    // long stretch, so the unit fills up and pushes back on its input.
    localparam int HOLD_AT_CHAR    = 600;
    localparam int HOLD_CYCLES     = 400;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   cycles;
    int   pending_chars;
    int   mismatches;
    // While set, neither side inserts idle cycles.
    bit   quiet;

    iptf_addr_if addr_if ();
    iptf_char_if char_if ();

    ip_address_text_formatter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .addr_ch     (addr_if),
        .char_ch     (char_if)
    );

    iptf_text_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .addr_valid    (addr_if.valid),
        .addr_ready    (addr_if.ready),
        .is_v6         (addr_if.is_v6),
        .addr_hi       (addr_if.addr_hi),
        .addr_lo       (addr_if.addr_lo),
        .char_valid    (char_if.valid),
        .char_ready    (char_if.ready),
        .char_code     (char_if.char_code),
        .last_char     (char_if.last_char),
        .pending_chars (pending_chars),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("ip_address_text_formatter_unit test failed");
        $finish;
    end

    // Offers one address. Valid is only lowered when an idle gap is drawn,
    // so back-to-back transfers never see valid dropped and raised again in
    // the same time step. Returns at the edge where the transfer happens.
    task automatic send_address(input logic v6, input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            addr_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        addr_if.valid   <= 1'b1;
        addr_if.is_v6   <= v6;
        addr_if.addr_hi <= hi;
        addr_if.addr_lo <= lo;
        do
            @(posedge clk);
        while (!addr_if.ready);
    endtask

    // Stops offering addresses and waits until every expected character has
    // arrived, then lets a few more cycles pass so that stray extra output
    // would still be caught. The count is a register in the checker, so the
    // first look waits for the next clock edge.
    task automatic wait_for_text(input int settle);
        addr_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Writes the hex case register; only called while the unit is idle.
    task automatic set_hex_case(input logic upper);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= upper;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver. Each character gets a random hold-off before ready is raised,
    // except during quiet stretches. Once, mid-run, it holds ready low for a
    // long stretch while the sender keeps offering addresses.
    initial
    begin
        int gap;
        int received;
        char_if.ready = 1'b0;
        received = 0;
        @(posedge rst_n);
        forever
        begin
            if (received == HOLD_AT_CHAR)
            begin
                char_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                char_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            char_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!char_if.valid);
            received++;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] grp;
        logic [7:0]  octet;
        int          kind;
        int          sel;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        addr_if.valid   = 1'b0;
        addr_if.is_v6   = 1'b0;
        addr_if.addr_hi = '0;
        addr_if.addr_lo = '0;
        quiet           = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed addresses run with upper case hex digits.
        set_hex_case(1'b1);

        // IPv4: unused upper bits set, zero and full octets, every digit count.
        send_address(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
        send_address(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_address(1'b0, 64'h0123_4567_89AB_CDEF, 64'h5A5A_A5A5_0A00_6409);
        send_address(1'b0, 64'h0000_0000_0000_0000, 64'h0000_0000_C0A8_01C8);
        send_address(1'b0, 64'h0000_0000_0000_0000, 64'h0000_0000_6301_0A63);

        // IPv6: all zero, all ones, no zero group at all.
        send_address(1'b1, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_address(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_address(1'b1, 64'h0001_0023_0456_789A, 64'hBCDE_F00F_0F00_FF00);
        // Runs at the start, the loopback form, and runs at the end.
        send_address(1'b1, 64'h0000_0000_0000_1234, 64'h5678_9ABC_DEF0_0001);
        send_address(1'b1, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_address(1'b1, 64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_address(1'b1, 64'hABCD_0012_0000_0000, 64'h0000_0000_0000_0000);
        // A single zero group still collapses.
        send_address(1'b1, 64'h2001_0DB8_0000_0001, 64'h0001_0001_0001_0001);
        // Ties between runs of two and of one go to the left-most run.
        send_address(1'b1, 64'h0001_0000_0000_0002, 64'h0003_0000_0000_0004);
        send_address(1'b1, 64'h0001_0000_0002_0003, 64'h0004_0000_0005_0006);
        // A longer run further right beats a shorter one on the left.
        send_address(1'b1, 64'h0001_0000_0002_0000, 64'h0000_0000_0003_0004);
        // Leading zeros within groups and every hex letter.
        send_address(1'b1, 64'h000F_00A0_0B00_C000, 64'hDEAD_BEEF_0ACE_0FED);
        wait_for_text(4);

        // Random passes alternate the hex case. Four in ten addresses are IPv4, half
        // are IPv6 built group by group so that zero runs of every length and
        // position appear, and one in ten is a fully random 128-bit IPv6 value.
        for (int pass = 0; pass < 3; pass++)
        begin
            set_hex_case(pass == 1);
            for (int n = 0; n < RANDOM_PER_PASS; n++)
            begin
                quiet = (n % 25) < 6;
                kind  = $urandom_range(0, 9);
                hi    = {$urandom, $urandom};
                lo    = {$urandom, $urandom};
                if (kind < 4)
                begin
                    v6 = 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        sel   = $urandom_range(0, 3);
                        octet = 8'($urandom);
                        case (sel)
                            0:       octet = 8'd0;
                            1:       octet = octet % 8'd10;
                            2:       octet = octet % 8'd100;
                            default: octet = octet;
                        endcase
                        lo[31 - 8 * i -: 8] = octet;
                    end
                end
                else
                begin
                    v6 = 1'b1;
                    if (kind < 9)
                    begin
                        for (int i = 0; i < NUM_GROUPS; i++)
                        begin
                            sel = $urandom_range(0, 7);
                            grp = 16'($urandom);
                            case (sel) inside
                                [0:2]:   grp = 16'h0000;
                                3:       grp = grp & 16'h000F;
                                4:       grp = grp & 16'h00FF;
                                5:       grp = grp & 16'h0FFF;
                                default: grp = grp;
                            endcase
                            if (i < 4)
                                hi[63 - 16 * i -: 16] = grp;
                            else
                                lo[63 - 16 * (i - 4) -: 16] = grp;
                        end
                    end
                end
                send_address(v6, hi, lo);
            end
            quiet = 1'b0;
            // The last pass waits out the full latency of one address.
            wait_for_text((pass == 2) ? 45 : 4);
        end

        if (mismatches == 0)
        begin
            $display("ip_address_text_formatter_unit test passed");
        end
        else
        begin
            $display("ip_address_text_formatter_unit test failed");
        end
        $finish;
    end

endmodule
